// File: src/sfk_pkg.sv
// Shared types for the segment frequency top-k block: payload structs,
// controller states and the control/status structs of the top-list.
// No dependencies.
`default_nettype none

package sfk_pkg;

  typedef struct packed {
    logic [7:0] octet_first;
    logic [7:0] octet_second;
    logic [7:0] octet_third;
    logic       end_of_log;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  segment_value;
    logic [15:0] segment_count;
    logic [3:0]  rank;
    logic        last_of_report;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD2,
    ST_RD3,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } list_cmd_t;

  typedef struct packed {
    logic head_nonzero;
    logic second_nonzero;
  } list_stat_t;

endpackage

`default_nettype wire

// File: src/sfk_top_list.sv
// Sorted top-k list held in registers: sorted insert and pop of the head.
// Depends on sfk_pkg.
`default_nettype none

module sfk_top_list #(
  parameter int TOP_K       = 10,
  parameter int IDX_W       = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sfk_pkg::list_cmd_t     cmd,
  input  logic [IDX_W-1:0]       ins_value,
  input  logic [COUNT_WIDTH-1:0] ins_count,
  output logic [IDX_W-1:0]       head_value,
  output logic [COUNT_WIDTH-1:0] head_count,
  output sfk_pkg::list_stat_t    stat
);
  import sfk_pkg::*;

  logic [IDX_W-1:0]       val [TOP_K];
  logic [COUNT_WIDTH-1:0] cnt [TOP_K];
  logic [TOP_K-1:0]       ge;

  assign head_value        = val[0];
  assign head_count        = cnt[0];
  assign stat.head_nonzero = (cnt[0] != '0);

  // An entry stays put when its count is at least the new one, so equal
  // counts keep the lower value (seen earlier in the sweep) ahead.
  for (genvar j = 0; j < TOP_K; j++) begin : g_cell
    assign ge[j] = (cnt[j] >= ins_count);

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt[j] <= '0;
        val[j] <= '0;
      end else if (cmd.insert) begin
        if (!ge[j]) begin
          if (j == 0) begin
            val[j] <= ins_value;
            cnt[j] <= ins_count;
          end else if (ge[(j == 0) ? 0 : j-1]) begin
            val[j] <= ins_value;
            cnt[j] <= ins_count;
          end else begin
            val[j] <= val[(j == 0) ? 0 : j-1];
            cnt[j] <= cnt[(j == 0) ? 0 : j-1];
          end
        end
      end else if (cmd.pop) begin
        if (j == TOP_K-1) begin
          val[j] <= '0;
          cnt[j] <= '0;
        end else begin
          val[j] <= val[(j == TOP_K-1) ? j : j+1];
          cnt[j] <= cnt[(j == TOP_K-1) ? j : j+1];
        end
      end
    end
  end

  if (TOP_K > 1) begin : g_second
    assign stat.second_nonzero = (cnt[(TOP_K > 1) ? 1 : 0] != '0);
  end else begin : g_single
    assign stat.second_nonzero = 1'b0;
  end

endmodule

`default_nettype wire

// File: src/segment_frequency_top_k_core.sv
// Segment frequency top-k: octet histogram in a count RAM with a sorted top list.
// Depends on sfk_pkg and sfk_top_list.
`default_nettype none

// For each accepted address its three octet counts are updated by
// read-modify-write on the count RAM, one read and one write per cycle, with
// forwarding of the previous write; no new address is taken until all three are
// read. An address marked end_of_log adds a sweep in which every count is read,
// each nonzero count is inserted into the sorted top list and every count is
// written back as zero; then the list is reported from the head, each result held
// while the result side stalls. After reset the RAM is cleared entry by entry before the first address is taken.
module segment_frequency_top_k_core #(
  parameter int VALUE_COUNT = 256,
  parameter int TOP_K       = 10,
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sfk_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output sfk_pkg::out_item_t result
);
  import sfk_pkg::*;

  localparam int IDX_W  = $clog2(VALUE_COUNT);
  localparam int RANK_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VALUE_COUNT - 1);

  state_t state, state_next;

  logic [IDX_W-1:0]       idx;
  logic                   idx_inc;
  logic [7:0]             oct2, oct3;
  logic                   last_q;
  logic                   capture;

  logic                   rd_en, rd_ok, rd_bump;
  logic [7:0]             rd_octet;
  logic                   rd_scan;
  logic [IDX_W-1:0]       rd_addr;

  logic                   pend_valid, pend_bump;
  logic [IDX_W-1:0]       pend_addr;

  logic [COUNT_WIDTH-1:0] mem [VALUE_COUNT];
  logic [COUNT_WIDTH-1:0] mem_q;
  logic                   clr_wr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   wr_en_q;
  logic [IDX_W-1:0]       wr_addr_q;
  logic [COUNT_WIDTH-1:0] wr_data_q;
  logic [COUNT_WIDTH-1:0] cur;

  list_cmd_t              list_cmd;
  list_stat_t             list_stat;
  logic [IDX_W-1:0]       head_value;
  logic [COUNT_WIDTH-1:0] head_count;
  logic                   emit_load;
  logic [RANK_W-1:0]      rank;

  // ---------------- controller ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (idx_inc) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (item_valid) state_next = ST_RD2;
      ST_RD2:   state_next = ST_RD3;
      ST_RD3:   state_next = last_q ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (idx == LAST_IDX) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT:  if (!list_stat.head_nonzero) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    capture    = 1'b0;
    clr_wr     = 1'b0;
    idx_inc    = 1'b0;
    rd_en      = 1'b0;
    rd_bump    = 1'b0;
    rd_scan    = 1'b0;
    rd_octet   = item.octet_first;
    emit_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clr_wr  = 1'b1;
        idx_inc = 1'b1;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          capture = 1'b1;
          rd_en   = 1'b1;
          rd_bump = 1'b1;
        end
      end
      ST_RD2: begin
        rd_en    = 1'b1;
        rd_bump  = 1'b1;
        rd_octet = oct2;
      end
      ST_RD3: begin
        rd_en    = 1'b1;
        rd_bump  = 1'b1;
        rd_octet = oct3;
      end
      ST_SCAN: begin
        rd_en   = 1'b1;
        rd_scan = 1'b1;
        idx_inc = 1'b1;
      end
      ST_DRAIN: ;
      ST_EMIT: begin
        emit_load = list_stat.head_nonzero && (!result_valid || result_ready);
      end
      default: ;
    endcase
  end

  // octets past the store are ignored
  assign rd_ok   = rd_scan || ({24'd0, rd_octet} < 32'(VALUE_COUNT));
  assign rd_addr = rd_scan ? idx : IDX_W'(rd_octet);

  always_ff @(posedge clk) begin
    if (capture) begin
      oct2   <= item.octet_second;
      oct3   <= item.octet_third;
      last_q <= item.end_of_log;
    end
  end

  // ---------------- count RAM ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      wr_en_q    <= 1'b0;
    end else begin
      pend_valid <= rd_en && rd_ok;
      wr_en_q    <= wr_en;
    end
    pend_bump <= rd_bump;
    pend_addr <= rd_addr;
    wr_addr_q <= wr_addr;
    wr_data_q <= wr_data;
  end

  // a write in the cycle of the read is not yet in the RAM data
  assign cur = (wr_en_q && (wr_addr_q == pend_addr)) ? wr_data_q : mem_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = '0;
    priority if (clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx;
    end else if (pend_valid) begin
      wr_en = 1'b1;
      if (pend_bump) begin
        wr_data = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // ---------------- top list and report ----------------
  assign list_cmd.insert = pend_valid && !pend_bump && (cur != '0);
  assign list_cmd.pop    = emit_load;

  sfk_top_list #(
    .TOP_K       (TOP_K),
    .IDX_W       (IDX_W),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_list (
    .clk        (clk),
    .rst        (rst),
    .cmd        (list_cmd),
    .ins_value  (pend_addr),
    .ins_count  (cur),
    .head_value (head_value),
    .head_count (head_count),
    .stat       (list_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      rank         <= '0;
    end else begin
      if (emit_load) begin
        result_valid <= 1'b1;
        rank         <= rank + 1'b1;
      end else begin
        if (result_ready) result_valid <= 1'b0;
        if (state == ST_DRAIN) rank <= '0;
      end
    end
    if (emit_load) begin
      result.segment_value  <= 8'(head_value);
      result.segment_count  <= 16'(head_count);
      result.rank           <= 4'(rank);
      result.last_of_report <= !list_stat.second_nonzero;
    end
  end

  // ---------------- checks ----------------
  a_no_insert_pop: assert property (@(posedge clk) disable iff (rst)
    !(list_cmd.insert && list_cmd.pop))
    else $error("top list insert and pop in the same cycle");

  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_bump) |-> (wr_en && wr_data == '0 && wr_addr == pend_addr))
    else $error("swept count entry not cleared");

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (!pend_valid && !rd_en))
    else $error("count RAM still busy during report");

  a_load_nonzero: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> (head_count != '0))
    else $error("result taken from an empty list entry");

endmodule

`default_nettype wire
